### src/segment_free_and_compaction_top_macros.svh
// ----------------------------------------------------------------------------
// segment_free_and_compaction_top_macros
// Assertion macros shared by the segment manager RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_FREE_AND_COMPACTION_TOP_MACROS_SVH
`define SEGMENT_FREE_AND_COMPACTION_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Operation and status codes of the segment table manager.
// ----------------------------------------------------------------------------
package sfc_pkg;

  // Address space width; it sets the address mask and span, but the port and table field widths are fixed.
  localparam int ADDRESS_BITS = 16;

  localparam logic [2:0] FUNC_CLEAR    = 3'd0;
  localparam logic [2:0] FUNC_LOAD_SEG = 3'd1;
  localparam logic [2:0] FUNC_LOAD_HOLE = 3'd2;
  localparam logic [2:0] FUNC_FREE     = 3'd3;
  localparam logic [2:0] FUNC_COMPACT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

endpackage

### src/segment_free_and_compaction_top.sv
// ----------------------------------------------------------------------------
// segment_free_and_compaction_top
// Segment and hole table manager: clear, load, free with hole merging, compaction.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata: func, segment_id, base, size
// m_axis    out  tdata: status..free_bytes, tlast: last
// cfg       in   free_bytes_start
// Each item is handled by a sequencer that moves through one table entry per
// cycle; a compaction moves a segment only when m_axis can take its result.
// A load walks the segment or the hole table, a free walks the segment table,
// then the hole table, and then merges pairs of holes, and a compaction walks
// the segment table. Reset is synchronous and clears counts and control. A
// stalled m_axis holds the result and keeps the block busy.
module segment_free_and_compaction_top
  import sfc_pkg::*;
#(
  parameter int SEGMENT_SLOTS = 16,
  parameter int HOLE_SLOTS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[2:0], segment_id[18:3], base[34:19], size[51:35], zero pad
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], move_source[17:2], move_target[33:18], move_length[50:34],
  // hole_base[67:51], hole_size[84:68], free_bytes[101:85], zero pad
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_wdata
);

  localparam int SW = $clog2(SEGMENT_SLOTS + 1);
  localparam int HW = $clog2(HOLE_SLOTS + 1);
  localparam int SI = $clog2(SEGMENT_SLOTS);
  localparam int HI = $clog2(HOLE_SLOTS);
  // Walk counters serve both tables, so they cover the larger one.
  localparam int CW = (SW > HW) ? SW : HW;
  localparam logic [16:0] SPAN = 17'(64'd1 << ADDRESS_BITS);
  localparam logic [15:0] AMASK = 16'((64'd1 << ADDRESS_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEG_FIND, S_SEG_SHIFT, S_HOLE_FIND, S_HOLE_SHIFT, S_FREE_FIND,
    S_FREE_REMOVE, S_MERGE, S_MERGE_SHIFT, S_CMP_MOVE, S_OUT
  } state_t;

  state_t        state;
  logic [15:0]   seg_id   [SEGMENT_SLOTS];
  logic [15:0]   seg_base [SEGMENT_SLOTS];
  logic [16:0]   seg_size [SEGMENT_SLOTS];
  logic [16:0]   hole_b   [HOLE_SLOTS];
  logic [16:0]   hole_s   [HOLE_SLOTS];
  logic [SW-1:0] seg_cnt;
  logic [HW-1:0] hole_cnt;
  logic [16:0]   free_cnt;
  logic [16:0]   start_reg;
  logic [2:0]    func;
  logic [15:0]   in_id, in_base;
  logic [16:0]   in_size;
  logic [16:0]   ins_b, ins_s;
  logic [CW-1:0] si, hi;
  logic [HW-1:0] hidx;
  logic [16:0]   extent, pack_end;
  logic [103:0]  out_data;
  logic          out_last;

  // Merge candidate sums, the saturating free count sum and the next pack address.
  logic [17:0]   mend, msum;
  logic [16:0]   fsum;
  logic [16:0]   pk_next;
  logic [16:0]   cmp_hb, cmp_hs;
  assign mend    = 18'(hole_b[hi[HI-1:0]]) + 18'(hole_s[hi[HI-1:0]]);
  assign msum    = 18'(hole_s[hi[HI-1:0]]) + 18'(hole_s[HI'(hi + 1'b1)]);
  assign fsum    = (18'(free_cnt) + 18'(ins_s) > 18'(SPAN)) ? SPAN
                 : 17'(free_cnt + ins_s);
  assign pk_next = 17'({1'b0, pack_end[15:0] & AMASK} + seg_size[si[SI-1:0]]);

  // Trailing hole after compaction: base saturated, size clipped at zero.
  assign cmp_hb  = (pack_end > SPAN) ? SPAN : pack_end;
  assign cmp_hs  = (extent > pack_end) ? 17'(extent - pack_end) : '0;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  function automatic logic [103:0] pack(input logic [1:0] st, input logic [15:0] src,
      input logic [15:0] tgt, input logic [16:0] len, input logic [16:0] hb,
      input logic [16:0] hs, input logic [16:0] fb);
    pack = {2'b00, fb, hs, hb, len, tgt, src, st};
  endfunction

  // Sequencer with table storage and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg_cnt <= '0;
      hole_cnt <= '0;
      free_cnt <= '0;
      start_reg <= 17'd65536;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) start_reg <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func    <= s_axis_tdata[2:0];
            in_id   <= s_axis_tdata[18:3];
            in_base <= s_axis_tdata[34:19] & AMASK;
            in_size <= s_axis_tdata[51:35];
            ins_b   <= {1'b0, s_axis_tdata[34:19] & AMASK};
            ins_s   <= s_axis_tdata[51:35];
            si <= '0;
            hi <= '0;
            out_last <= 1'b1;
            unique case (s_axis_tdata[2:0])
              FUNC_CLEAR: begin
                seg_cnt <= '0;
                hole_cnt <= '0;
                free_cnt <= start_reg;
                out_data <= pack(ST_OK, '0, '0, '0, '0, '0, start_reg);
                m_axis_tvalid <= 1'b1;
                state <= S_OUT;
              end
              FUNC_LOAD_SEG: begin
                if (seg_cnt >= SW'(SEGMENT_SLOTS)) begin
                  out_data <= pack(ST_FULL, '0, '0, '0, '0, '0, free_cnt);
                  m_axis_tvalid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  state <= S_SEG_FIND;
                end
              end
              FUNC_LOAD_HOLE: begin
                if (hole_cnt >= HW'(HOLE_SLOTS)) begin
                  out_data <= pack(ST_FULL, '0, '0, '0, '0, '0, free_cnt);
                  m_axis_tvalid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  state <= S_HOLE_FIND;
                end
              end
              FUNC_FREE: begin
                state <= S_FREE_FIND;
              end
              FUNC_COMPACT: begin
                if (seg_cnt == '0) begin
                  out_data <= pack(ST_EMPTY, '0, '0, '0, '0, '0, free_cnt);
                  m_axis_tvalid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  pack_end <= '0;
                  if (hole_cnt == '0 || {1'b0, seg_base[SI'(seg_cnt - 1'b1)]} >
                      hole_b[HI'(hole_cnt - 1'b1)])
                    extent <= 17'(seg_base[SI'(seg_cnt - 1'b1)]
                            + seg_size[SI'(seg_cnt - 1'b1)]);
                  else
                    extent <= 17'(hole_b[HI'(hole_cnt - 1'b1)]
                            + hole_s[HI'(hole_cnt - 1'b1)]);
                  state <= S_CMP_MOVE;
                end
              end
              default: begin
                out_data <= pack(ST_OK, '0, '0, '0, '0, '0, free_cnt);
                m_axis_tvalid <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end
        end
        // Find the insertion place: after all entries with base <= new base.
        S_SEG_FIND: begin
          if (si < CW'(seg_cnt) && seg_base[si[SI-1:0]] <= in_base) si <= si + 1'b1;
          else begin
            hi <= CW'(seg_cnt);
            state <= S_SEG_SHIFT;
          end
        end
        // Shift entries up one by one from the top, then write the new one.
        S_SEG_SHIFT: begin
          if (si < hi) begin
            seg_id[SI'(hi)]   <= seg_id[SI'(hi - 1'b1)];
            seg_base[SI'(hi)] <= seg_base[SI'(hi - 1'b1)];
            seg_size[SI'(hi)] <= seg_size[SI'(hi - 1'b1)];
            hi <= hi - 1'b1;
          end else begin
            seg_id[si[SI-1:0]]   <= in_id;
            seg_base[si[SI-1:0]] <= in_base;
            seg_size[si[SI-1:0]] <= in_size;
            seg_cnt <= seg_cnt + 1'b1;
            out_data <= pack(ST_OK, '0, '0, '0, '0, '0, free_cnt);
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_HOLE_FIND: begin
          if (hi < CW'(hole_cnt) && hole_b[hi[HI-1:0]] <= ins_b) hi <= hi + 1'b1;
          else begin
            hidx <= HW'(hi);
            si <= CW'(hole_cnt);
            state <= S_HOLE_SHIFT;
          end
        end
        S_HOLE_SHIFT: begin
          if (si > CW'(hidx)) begin
            hole_b[HI'(si)] <= hole_b[HI'(si - 1'b1)];
            hole_s[HI'(si)] <= hole_s[HI'(si - 1'b1)];
            si <= si - 1'b1;
          end else begin
            hole_b[hidx[HI-1:0]] <= ins_b;
            hole_s[hidx[HI-1:0]] <= ins_s;
            hole_cnt <= hole_cnt + 1'b1;
            if (func == FUNC_FREE) begin
              hi <= '0;
              state <= S_MERGE;
            end else begin
              out_data <= pack(ST_OK, '0, '0, '0, '0, '0, free_cnt);
              m_axis_tvalid <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        // Search the first segment with a matching id.
        S_FREE_FIND: begin
          if (si >= CW'(seg_cnt)) begin
            out_data <= pack(ST_NOT_FOUND, '0, '0, '0, '0, '0, free_cnt);
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end else if (seg_id[si[SI-1:0]] == in_id) begin
            if (hole_cnt >= HW'(HOLE_SLOTS)) begin
              out_data <= pack(ST_FULL, '0, '0, '0, '0, '0, free_cnt);
              m_axis_tvalid <= 1'b1;
              state <= S_OUT;
            end else begin
              ins_b <= {1'b0, seg_base[si[SI-1:0]]};
              ins_s <= seg_size[si[SI-1:0]];
              in_base <= seg_base[si[SI-1:0]];
              state <= S_FREE_REMOVE;
            end
          end else si <= si + 1'b1;
        end
        // Close the gap in the segment table.
        S_FREE_REMOVE: begin
          if (si + 1'b1 < CW'(seg_cnt)) begin
            seg_id[si[SI-1:0]]   <= seg_id[SI'(si + 1'b1)];
            seg_base[si[SI-1:0]] <= seg_base[SI'(si + 1'b1)];
            seg_size[si[SI-1:0]] <= seg_size[SI'(si + 1'b1)];
            si <= si + 1'b1;
          end else begin
            seg_cnt <= seg_cnt - 1'b1;
            free_cnt <= fsum;
            hi <= '0;
            state <= S_HOLE_FIND;
          end
        end
        // Walk pairs of holes; merge when one ends where the next starts.
        S_MERGE: begin
          if (hi + 1'b1 < CW'(hole_cnt)) begin
            if (mend == 18'(hole_b[HI'(hi + 1'b1)])) begin
              hole_s[hi[HI-1:0]] <= (msum > 18'(SPAN)) ? SPAN : msum[16:0];
              if (CW'(hidx) > hi) hidx <= hidx - 1'b1;
              si <= hi + 1'b1;
              state <= S_MERGE_SHIFT;
            end else hi <= hi + 1'b1;
          end else begin
            out_data <= pack(ST_OK, '0, '0, '0, hole_b[hidx[HI-1:0]],
                             hole_s[hidx[HI-1:0]], free_cnt);
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_MERGE_SHIFT: begin
          if (si + 1'b1 < CW'(hole_cnt)) begin
            hole_b[HI'(si)] <= hole_b[HI'(si + 1'b1)];
            hole_s[HI'(si)] <= hole_s[HI'(si + 1'b1)];
            si <= si + 1'b1;
          end else begin
            hole_cnt <= hole_cnt - 1'b1;
            state <= S_MERGE;
          end
        end
        // One move result per segment, then a final result with the trailing hole.
        S_CMP_MOVE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            if (si < CW'(seg_cnt)) begin
              out_data <= pack(ST_OK, seg_base[si[SI-1:0]], pack_end[15:0] & AMASK,
                               seg_size[si[SI-1:0]], '0, '0, free_cnt);
              out_last <= 1'b0;
              m_axis_tvalid <= 1'b1;
              seg_base[si[SI-1:0]] <= pack_end[15:0] & AMASK;
              pack_end <= pk_next;
              si <= si + 1'b1;
            end else begin
              hole_b[0] <= cmp_hb;
              hole_s[0] <= cmp_hs;
              hole_cnt <= HW'(1);
              out_data <= pack(ST_OK, '0, '0, '0, cmp_hb, cmp_hs, free_cnt);
              out_last <= 1'b1;
              m_axis_tvalid <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "segment_free_and_compaction_top_macros.svh"

  `SFC_ASSERT_IMP(a_busy_no_ready, clk, rst, m_axis_tvalid, !s_axis_tready, "ready when busy")
  `SFC_ASSERT_IMP(a_seg_bound, clk, rst, 1'b1, seg_cnt <= SW'(SEGMENT_SLOTS), "seg overflow")
  `SFC_ASSERT_IMP(a_hole_bound, clk, rst, 1'b1, hole_cnt <= HW'(HOLE_SLOTS), "hole overflow")
  `SFC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule
